// File: hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
package swm_pkg;

  // Sample and register widths, default window maximum and reset window size
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned WINDOW_MAX_DEF = 64;
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_ROT  = 4'b0100,
    ST_SEL  = 4'b1000
  } swm_state_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;   // take the new sample, push the line one cell older
    logic load;    // copy the stored sample into the ring, clear the rank
    logic rotate;  // count one comparison, pass the ring copy on
  } swm_ctrl_t;

endpackage

// File: hw/rtl/swm_cell.sv
// One window cell: stored sample, rotating ring copy and rank counter.
module swm_cell #(
  parameter int unsigned N  = 64,
  parameter int unsigned ID = 0,
  parameter int unsigned IW = (N > 1) ? $clog2(N) : 1,
  parameter int unsigned WW = $clog2(N + 1)
) (
  input  logic                           clk,
  input  swm_pkg::swm_ctrl_t             ctrl,
  input  logic signed [swm_pkg::DATA_W-1:0] shift_in,
  output logic signed [swm_pkg::DATA_W-1:0] value,
  input  logic signed [swm_pkg::DATA_W-1:0] copy_in,
  input  logic [IW-1:0]                  copy_idx_in,
  output logic signed [swm_pkg::DATA_W-1:0] copy,
  output logic [IW-1:0]                  copy_idx,
  input  logic [WW-1:0]                  win_len,
  input  logic [IW-1:0]                  target,
  output logic                           sel
);
  import swm_pkg::*;

  logic [IW-1:0] rank;
  logic          copy_in_win;
  logic          own_in_win;
  logic          hit;

  // Compare the visiting copy against the stored sample; ties break on age
  assign copy_in_win = WW'(copy_idx) < win_len;
  assign own_in_win  = WW'(ID) < win_len;
  assign hit = copy_in_win &&
               ((copy < value) || ((copy == value) && (copy_idx < IW'(ID))));

  // Advance the sample line
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= shift_in;
    end
  end

  // Load or rotate the ring copy, accumulate the rank
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      copy     <= value;
      copy_idx <= IW'(ID);
      rank     <= '0;
    end else if (ctrl.rotate) begin
      copy     <= copy_in;
      copy_idx <= copy_idx_in;
      rank     <= rank + IW'(hit);
    end
  end

  // Flag the cell that holds the wanted rank
  assign sel = own_in_win && (rank == target);

endmodule

// File: hw/rtl/sliding_window_median_top.sv
// Sliding-window lower-median filter: sequencer, cell chain and output register.
// A request that completes a window has its median selected after a load step,
// a rotation of the copies once round the ring of N cells and a select step.
// The input stalls until the sequencer is back in idle, so no new request is taken
// while one is in flight; a request that gives no result leaves the input free.
// Reset (rst, synchronous): clears the fill count, sequencer and output valid,
// and sets the window size to 3; stored samples stay undefined until written.
module sliding_window_median_top #(
  parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic                              first,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [swm_pkg::DATA_W-1:0] median,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata
);
  import swm_pkg::*;

  localparam int unsigned N  = WINDOW_MAX;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned WW = $clog2(N + 1);

  swm_state_t           state;
  logic [CFG_W-1:0]     window_size;
  logic [WW-1:0]        fill_count;
  logic [WW-1:0]        fill_next;
  logic [WW-1:0]        win_len;
  logic [IW-1:0]        target;
  logic [IW-1:0]        step;
  logic                 accept;
  logic                 out_take;
  swm_ctrl_t            ctrl;

  logic signed [DATA_W-1:0] value    [N];
  logic signed [DATA_W-1:0] copy     [N];
  logic [IW-1:0]            copy_idx [N];
  logic [N-1:0]             sel_vec;
  logic signed [DATA_W-1:0] sel_word;

  // Clamp the window size to 1..N
  always_comb begin
    if (window_size == '0) begin
      win_len = WW'(1);
    end else if (32'(window_size) > N) begin
      win_len = WW'(N);
    end else begin
      win_len = WW'(window_size);
    end
  end

  assign target = IW'((win_len - WW'(1)) >> 1);

  // Handshake
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Restart, advance or saturate the fill count
  always_comb begin
    if (first) begin
      fill_next = WW'(1);
    end else if (fill_count < WW'(N)) begin
      fill_next = fill_count + WW'(1);
    end else begin
      fill_next = fill_count;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  // Cell control
  assign ctrl.shift  = accept;
  assign ctrl.load   = (state == ST_LOAD);
  assign ctrl.rotate = (state == ST_ROT);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      step       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            fill_count <= fill_next;
            if (fill_next >= win_len) begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          step  <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (step == IW'(N - 1)) begin
            state <= ST_SEL;
          end else begin
            step <= step + IW'(1);
          end
        end
        ST_SEL: begin
          if (!out_valid || out_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Chain of cells: sample line and rotation ring
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? N - 1 : i - 1;
    swm_cell #(
      .N  (N),
      .ID (i),
      .IW (IW),
      .WW (WW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .shift_in    ((i == 0) ? sample : value[PREV]),
      .value       (value[i]),
      .copy_in     (copy[PREV]),
      .copy_idx_in (copy_idx[PREV]),
      .copy        (copy[i]),
      .copy_idx    (copy_idx[i]),
      .win_len     (win_len),
      .target      (target),
      .sel         (sel_vec[i])
    );
  end

  // Gather the sample of the selected cell
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < N; i++) begin
      sel_word = sel_word | (sel_vec[i] ? value[i] : '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SEL && (!out_valid || out_take)) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEL && (!out_valid || out_take)) begin
      median <= sel_word;
    end
  end

  // Checks
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_IDLE)
    else $error("request accepted outside idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= WW'(N))
    else $error("fill count above window maximum");

  a_rot_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT && step == IW'(N - 1)) |=> state == ST_SEL)
    else $error("ring rotation did not end in select");

  a_one_winner: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEL |-> $onehot(sel_vec))
    else $error("rank select not unique");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL && (!out_valid || out_take)) |=> out_valid && state == ST_IDLE)
    else $error("result not loaded after select");

endmodule

// File: bench/sliding_window_median_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding-window median filter: follows both channels and predicts each median.
module sliding_window_median_checker #(
  parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic                              first,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [swm_pkg::DATA_W-1:0] median,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                mismatch_count,
  output int                                medians_due
);
  import swm_pkg::*;

  // Own copy of the filter state
  logic signed [DATA_W-1:0] history [WINDOW_MAX];
  int unsigned              fill_count;
  int unsigned              write_slot;
  logic [CFG_W-1:0]         window_cfg;
  logic signed [DATA_W-1:0] median_queue [$];
  logic signed [DATA_W-1:0] expected;

  // Clamp the programmed size to 1..WINDOW_MAX
  function automatic int unsigned active_window();
    if (window_cfg == '0) return 1;
    if (window_cfg > WINDOW_MAX) return WINDOW_MAX;
    return 32'(window_cfg);
  endfunction

  // Sort the newest len samples and pick the lower median
  function automatic logic signed [DATA_W-1:0] newest_lower_median(input int unsigned len);
    logic signed [DATA_W-1:0] keys [WINDOW_MAX];
    logic signed [DATA_W-1:0] key;
    int unsigned              slot;
    int                       i;
    int                       j;
    slot = write_slot;
    for (i = 0; i < len; i++) begin
      slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
      keys[i] = history[slot];
    end
    for (i = 1; i < len; i++) begin
      key = keys[i];
      j = i;
      while (j > 0 && keys[j-1] > key) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = key;
    end
    return keys[(len - 1) / 2];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_count = 0;
      write_slot = 0;
      window_cfg = WIN_RESET;
      median_queue.delete();
    end else begin
      // Check a delivered median against the oldest prediction
      if (out_valid && !out_stall) begin
        if (median_queue.size() == 0) begin
          $display("%0t: median %0d delivered with none expected", $time, median);
          mismatch_count++;
        end else begin
          expected = median_queue.pop_front();
          if (median !== expected) begin
            $display("%0t: median mismatch: expected %0d, actual %0d",
                     $time, expected, median);
            mismatch_count++;
          end
        end
      end

      // Track the window size register
      if (cfg_we) begin
        window_cfg = cfg_wdata;
      end

      // Store an accepted request and predict its median once the window is full
      if (in_valid && !in_stall) begin
        if (first) begin
          fill_count = 0;
          write_slot = 0;
        end
        history[write_slot] = sample;
        write_slot = (write_slot + 1) % WINDOW_MAX;
        if (fill_count < WINDOW_MAX) fill_count++;
        if (fill_count >= active_window()) begin
          median_queue = {median_queue, newest_lower_median(active_window())};
        end
      end
    end
    medians_due = median_queue.size();
  end

endmodule

// File: bench/sliding_window_median_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sliding-window median filter: clock, reset, stimulus and verdict.
module sliding_window_median_top_tb;
  import swm_pkg::*;

  localparam int unsigned WINDOW_MAX  = WINDOW_MAX_DEF;
  localparam int unsigned SETTLE      = WINDOW_MAX + 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES      = 14;
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample;
  logic                     first;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] median;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;
  int                       mismatch_count;
  int                       medians_due;
  int unsigned              cycle_count;
  int unsigned              gap_odds;    // 1 in gap_odds requests idles first; 0 = never
  int unsigned              stall_odds;  // 1 in stall_odds cycles starts a stall; 0 = never
  logic signed [DATA_W-1:0] last_sample;
  int unsigned              phase_sizes [PHASES] =
    '{64, 1, 5, 127, 2, 0, 16, 3, 63, 65, 8, 31, 0, 0};

  sliding_window_median_top #(.WINDOW_MAX(WINDOW_MAX)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .first     (first),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .median    (median),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sliding_window_median_checker #(.WINDOW_MAX(WINDOW_MAX)) median_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .first          (first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median         (median),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .medians_due    (medians_due)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("sliding_window_median_top_tb NOT OK");
    $finish;
  end

  // Stall the result channel in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic signed [DATA_W-1:0] value, input logic is_first);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    first    <= is_first;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    last_sample = value;
  endtask

  // Drain the filter, then program a new window size
  task automatic set_window(input logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    while (medians_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix extremes, near-extremes, small values with ties, repeats and full-range values
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return S_MIN + $urandom_range(0, 3);
      3:       return S_MAX - $urandom_range(0, 3);
      4, 5:    return $signed($urandom_range(0, 15)) - 8;
      6:       return last_sample;
      default: return $urandom();
    endcase
  endfunction

  // Random phase at one window size; restarts get rarer as the window grows
  task automatic run_phase(input logic [CFG_W-1:0] size, input int unsigned count,
                           input logic busy);
    int unsigned span;
    int unsigned n;
    logic        restart;
    span = (size == '0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : size;
    set_window(size);
    if (busy && $urandom_range(0, 3) != 0) begin
      gap_odds   = $urandom_range(2, 8);
      stall_odds = $urandom_range(2, 8);
    end else begin
      gap_odds   = 0;
      stall_odds = 0;
    end
    for (n = 0; n < count; n++) begin
      restart = (n == 0 && $urandom_range(0, 1) == 1) ||
                $urandom_range(0, 3 * span + 10) == 0;
      send_request(pick_sample(), restart);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample      = '0;
    first       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    gap_odds    = 4;
    stall_odds  = 4;
    last_sample = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window of three: extremes, ties and a restart mid-sequence
    send_request(S_MAX, 1'b1);
    send_request(S_MIN, 1'b0);
    send_request(0, 1'b0);
    send_request(-1, 1'b0);
    send_request(1, 1'b0);
    send_request(S_MIN, 1'b0);
    send_request(S_MIN, 1'b0);
    send_request(S_MAX, 1'b0);
    send_request(5, 1'b1);
    send_request(5, 1'b0);
    send_request(-5, 1'b0);

    // Size zero acts as one, so every request gives a median, restart or not
    set_window(7'd0);
    send_request(S_MIN, 1'b0);
    send_request(S_MAX, 1'b1);

    // Even window: take the lower of the two middle values
    set_window(7'd2);
    send_request(7, 1'b0);
    send_request(-7, 1'b1);
    send_request(-8, 1'b0);

    // Oversized window saturates; the window is far from full
    set_window(7'd127);
    send_request(S_MAX - 1, 1'b0);
    send_request(S_MIN + 1, 1'b0);

    // Shrink mid-sequence: the fill count already covers the new size
    set_window(7'd4);
    send_request(2, 1'b0);
    send_request(S_MAX, 1'b0);

    // Random phases, the last one with no idling on either side
    phase_sizes[PHASES-2] = $urandom_range(0, 127);
    phase_sizes[PHASES-1] = $urandom_range(1, 12);
    for (int unsigned p = 0; p < PHASES; p++) begin
      run_phase(CFG_W'(phase_sizes[p]), 115, p != PHASES - 1);
    end

    // Drain and let the filter settle before the verdict
    in_valid <= 1'b0;
    while (medians_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("sliding_window_median_top_tb OK");
    end else begin
      $display("sliding_window_median_top_tb NOT OK");
    end
    $finish;
  end

endmodule
